### design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the design files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/bol_pkg.sv
// ---------------------------------------------------------------------------
// bol_pkg
// Types and constants of the bounded ordered list.
// ---------------------------------------------------------------------------
package bol_pkg;

   localparam int DATA_W     = 32;
   localparam int ACTION_W   = 3;
   localparam int POS_W      = 8;
   localparam int STATUS_W   = 2;
   localparam int OUT_CNT_W  = 5;
   localparam int REQ_DATA_W = 40;  // value + position, padded to bytes
   localparam int RSP_DATA_W = 40;  // status + value + count, padded to bytes

   typedef enum logic [ACTION_W-1:0] {
      ACT_ADD_FRONT    = 3'd0,
      ACT_ADD_END      = 3'd1,
      ACT_REMOVE_FRONT = 3'd2,
      ACT_REMOVE_END   = 3'd3,
      ACT_INSERT_AT    = 3'd4,
      ACT_READOUT      = 3'd5
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_RANGE = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   // What one storage cell does in a cycle
   typedef enum logic [2:0] {
      OP_HOLD,
      OP_LOAD,
      OP_FROM_LEFT,
      OP_FROM_RIGHT,
      OP_FROM_HEAD
   } cell_op_type;

   // Command broadcast to the row of cells
   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_INSERT,
      CMD_SHIFT_FRONT,
      CMD_ROTATE
   } cmd_type;

   typedef enum logic {
      FSM_IDLE,
      FSM_READ
   } fsm_state_type;

endpackage

### design/bol_cell.sv
// ---------------------------------------------------------------------------
// bol_cell
// One storage cell of the list: holds an entry, loads a new value or takes
// the entry of a neighbor or of the head cell.
// ---------------------------------------------------------------------------
module bol_cell (
   input  logic                        clock,
   input  bol_pkg::cell_op_type        op,
   input  logic [bol_pkg::DATA_W-1:0]  load_data,
   input  logic [bol_pkg::DATA_W-1:0]  left_data,
   input  logic [bol_pkg::DATA_W-1:0]  right_data,
   input  logic [bol_pkg::DATA_W-1:0]  head_data,
   output logic [bol_pkg::DATA_W-1:0]  data_out
);
   import bol_pkg::*;

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   // next entry
   always_comb begin
      unique case (op)
         OP_HOLD:       data_in = data_ff;
         OP_LOAD:       data_in = load_data;
         OP_FROM_LEFT:  data_in = left_data;
         OP_FROM_RIGHT: data_in = right_data;
         OP_FROM_HEAD:  data_in = head_data;
         default:       data_in = data_ff;
      endcase
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

### design/bounded_ordered_list_top.sv
// ---------------------------------------------------------------------------
// bounded_ordered_list_top
// Ordered list of up to CAPACITY signed 32-bit entries kept in a row of
// shifting cells, front in cell 0.
// ---------------------------------------------------------------------------
//  Channel | Ports           | Dir | Payload
//  req     | req_t*          | in  | tuser: action; tdata: value, position
//  rsp     | rsp_t*          | out | tdata: status, item_value, entry_count;
//          |                 |     | tuser: item_valid; tlast: last_of_run
//
//  Add, insert and front removal shift the affected cells at once; end removal
//  only lowers the count. Readout sends the entries out through cell 0 while the
//  occupied part of the row rotates by one a cycle when rsp is free, ending in its old order.
//  Reset clears the entry count and the control; cell contents are not reset.
//  A stalled rsp holds its item in the output register; req is taken again
//  outside a readout as soon as that register is free or drains in the same cycle.
// ---------------------------------------------------------------------------
module bounded_ordered_list_top #(
   parameter int CAPACITY = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [bol_pkg::REQ_DATA_W-1:0]   req_tdata,  // value[31:0], position[39:32]
   input  logic [bol_pkg::ACTION_W-1:0]     req_tuser,  // action[2:0]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [bol_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // status[1:0], item_value[33:2],
                                                        // entry_count[38:34], zero[39]
   output logic                             rsp_tuser,  // item_valid[0]
   output logic                             rsp_tlast
);
   import bol_pkg::*;

   `include "assert_macros.svh"

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   // control state
   fsm_state_type              state_ff, state_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [CNT_W-1:0]           rd_ff, rd_in;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   status_type                 out_status_ff, o_status;
   logic [DATA_W-1:0]          out_value_ff, o_value;
   logic                       out_valid_ff, o_valid;
   logic                       out_last_ff, o_last;
   logic [OUT_CNT_W-1:0]       out_count_ff;

   // decode
   logic                       req_accept;
   logic                       out_free;
   logic                       load_out;
   action_type                 action;
   logic [DATA_W-1:0]          req_value;
   logic [POS_W-1:0]           req_pos;
   logic [CMP_W-1:0]           pos_ext;
   logic [CMP_W-1:0]           cnt_p1;
   logic                       is_full;
   logic                       is_empty;
   logic [CNT_W-1:0]           last_idx;
   logic                       rd_last;

   // cell row
   cmd_type                    cmd;
   logic [CNT_W-1:0]           ins_idx;
   logic [DATA_W-1:0]          cell_q  [CAPACITY];
   cell_op_type                cell_op [CAPACITY];

   assign req_value  = req_tdata[DATA_W-1:0];
   assign req_pos    = req_tdata[DATA_W+POS_W-1:DATA_W];
   assign action     = action_type'(req_tuser);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == FSM_IDLE) && out_free;
   assign req_accept = req_tvalid && req_tready;
   assign pos_ext    = CMP_W'(req_pos);
   assign cnt_p1     = CMP_W'(count_ff) + CMP_W'(1);
   assign is_full    = (count_ff == CNT_W'(CAPACITY));
   assign is_empty   = (count_ff == '0);
   assign last_idx   = count_ff - CNT_W'(1);
   assign rd_last    = (rd_ff == last_idx);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_accept && action == ACT_READOUT && !is_empty) begin
               state_in = FSM_READ;
            end
         end
         FSM_READ: begin
            if (out_free && rd_last) begin
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // actions, row command and result
   always_comb begin
      cmd      = CMD_HOLD;
      ins_idx  = '0;
      count_in = count_ff;
      rd_in    = rd_ff;
      load_out = 1'b0;
      o_status = ST_OK;
      o_value  = '0;
      o_valid  = 1'b0;
      o_last   = 1'b1;
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_accept) begin
               load_out = 1'b1;
               unique case (action)
                  ACT_ADD_FRONT, ACT_ADD_END, ACT_INSERT_AT: begin
                     priority if (is_full) begin
                        o_status = ST_FULL;
                     end else if (action == ACT_ADD_FRONT ||
                                  (action == ACT_INSERT_AT && pos_ext <= CMP_W'(1))) begin
                        cmd      = CMD_INSERT;
                        ins_idx  = '0;
                        count_in = count_ff + CNT_W'(1);
                     end else if (action == ACT_ADD_END) begin
                        cmd      = CMD_INSERT;
                        ins_idx  = count_ff;
                        count_in = count_ff + CNT_W'(1);
                     end else if (pos_ext > cnt_p1) begin
                        o_status = ST_RANGE;
                     end else begin
                        cmd      = CMD_INSERT;
                        ins_idx  = CNT_W'(pos_ext - CMP_W'(1));
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  ACT_REMOVE_FRONT: begin
                     if (is_empty) begin
                        o_status = ST_EMPTY;
                     end else begin
                        cmd      = CMD_SHIFT_FRONT;
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  ACT_REMOVE_END: begin
                     if (is_empty) begin
                        o_status = ST_EMPTY;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  ACT_READOUT: begin
                     // empty list: one not-valid item, else stream from FSM_READ
                     if (!is_empty) begin
                        load_out = 1'b0;
                        rd_in    = '0;
                     end
                  end
                  default: ;  // unused codes: plain ok status
               endcase
            end
         end
         FSM_READ: begin
            if (out_free) begin
               load_out = 1'b1;
               cmd      = CMD_ROTATE;
               o_value  = cell_q[0];
               o_valid  = 1'b1;
               o_last   = rd_last;
               rd_in    = rd_ff + CNT_W'(1);
            end
         end
         default: ;
      endcase
   end

   // output valid
   always_comb begin
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         rd_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_ff        <= rd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (load_out) begin
         out_status_ff <= o_status;
         out_value_ff  <= o_value;
         out_valid_ff  <= o_valid;
         out_last_ff   <= o_last;
         out_count_ff  <= OUT_CNT_W'(count_in);
      end
   end

   // row of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam logic [CNT_W-1:0] CELL_I = CNT_W'(i);
      logic [DATA_W-1:0] left_d;
      logic [DATA_W-1:0] right_d;

      if (i == 0) begin : g_first
         assign left_d = '0;
      end else begin : g_mid_l
         assign left_d = cell_q[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_d = '0;
      end else begin : g_mid_r
         assign right_d = cell_q[i+1];
      end

      // per-cell operation from the broadcast command
      always_comb begin
         unique case (cmd)
            CMD_INSERT: begin
               if (CELL_I == ins_idx) begin
                  cell_op[i] = OP_LOAD;
               end else if (CELL_I > ins_idx) begin
                  cell_op[i] = OP_FROM_LEFT;
               end else begin
                  cell_op[i] = OP_HOLD;
               end
            end
            CMD_SHIFT_FRONT: begin
               cell_op[i] = (i == CAPACITY - 1) ? OP_HOLD : OP_FROM_RIGHT;
            end
            CMD_ROTATE: begin
               if (CELL_I == last_idx) begin
                  cell_op[i] = OP_FROM_HEAD;
               end else if (CELL_I < last_idx) begin
                  cell_op[i] = OP_FROM_RIGHT;
               end else begin
                  cell_op[i] = OP_HOLD;
               end
            end
            default: cell_op[i] = OP_HOLD;
         endcase
      end

      bol_cell u_cell (
         .clock      (clock),
         .op         (cell_op[i]),
         .load_data  (req_value),
         .left_data  (left_d),
         .right_data (right_d),
         .head_data  (cell_q[0]),
         .data_out   (cell_q[i])
      );
   end

   // response ports
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, out_count_ff, out_value_ff, out_status_ff};
   assign rsp_tuser  = out_valid_ff;
   assign rsp_tlast  = out_last_ff;

   // checks
   `ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(CAPACITY), "entry count above capacity")
   `ASSERT_IMPL(a_read_blocks, state_ff == FSM_READ, !req_tready, "item taken during readout")
   `ASSERT_NEXT(a_read_count, state_ff == FSM_READ, $stable(count_ff), "count moved in readout")
   `ASSERT_NEXT(a_empty_pop, req_accept && action == ACT_REMOVE_FRONT && is_empty,
                rsp_valid_ff && out_status_ff == ST_EMPTY, "empty removal not reported")

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for bounded_ordered_list_top. A short directed table
// covers empty, full and out-of-range cases, the unused action codes and the
// value and position extremes. Fill, drain and mixed phases of random items
// follow. Every reply is checked against an in-bench model of the list or its typed row.
// ---------------------------------------------------------------------------
module testbench;
   import bol_pkg::*;

   localparam int LIST_DEPTH      = 16;
   localparam int NUM_DIRECTED    = 25;
   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 29;
   localparam int PRESSURE_PHASE  = 3;
   localparam int PRESSURE_ITEMS  = 25;
   localparam int LONG_HOLD       = 300;
   localparam int DRAIN_CYCLES    = 40;
   localparam int CYCLE_LIMIT     = 500000;
   localparam int MAX_REPORTS     = 10;

   // Action codes the block leaves unused
   localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

   typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_type;

   // One reply as it leaves the block
   typedef struct packed {
      status_type           st;
      logic [DATA_W-1:0]    val;
      logic                 valid;
      logic                 last;
      logic [OUT_CNT_W-1:0] cnt;
   } list_reply_type;

   // Directed row; typed rows carry their single status reply
   typedef struct packed {
      logic [ACTION_W-1:0]  act;
      logic [DATA_W-1:0]    val;
      logic [POS_W-1:0]     pos;
      int                   reps;
      bit                   typed;
      status_type           st;
      logic [OUT_CNT_W-1:0] cnt;
   } stim_row_type;

   localparam stim_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      '{ACT_REMOVE_FRONT, 32'h0000_0000, 8'd0,   1,  1'b1, ST_EMPTY, 5'd0},
      '{ACT_REMOVE_END,   32'h0000_0000, 8'd0,   1,  1'b1, ST_EMPTY, 5'd0},
      '{ACT_READOUT,      32'h0000_0000, 8'd0,   1,  1'b1, ST_OK,    5'd0},
      '{ACT_ADD_FRONT,    32'h7FFF_FFFF, 8'd0,   1,  1'b1, ST_OK,    5'd1},
      '{ACT_ADD_END,      32'h8000_0000, 8'd0,   1,  1'b1, ST_OK,    5'd2},
      '{ACT_INSERT_AT,    32'hFFFF_FFFF, 8'd0,   1,  1'b1, ST_OK,    5'd3},
      '{ACT_INSERT_AT,    32'h0000_0001, 8'd255, 1,  1'b1, ST_RANGE, 5'd3},
      '{ACT_INSERT_AT,    32'h0000_0002, 8'd5,   1,  1'b1, ST_RANGE, 5'd3},
      '{ACT_INSERT_AT,    32'h0000_0000, 8'd4,   1,  1'b1, ST_OK,    5'd4},
      '{ACT_INSERT_AT,    32'h5555_AAAA, 8'd2,   1,  1'b1, ST_OK,    5'd5},
      '{ACT_INSERT_AT,    32'hAAAA_5555, 8'd1,   1,  1'b1, ST_OK,    5'd6},
      '{ACT_READOUT,      32'h0000_0000, 8'd0,   1,  1'b0, ST_OK,    5'd0},
      '{ACT_SPARE_LO,     32'hFFFF_FFFF, 8'd255, 1,  1'b1, ST_OK,    5'd6},
      '{ACT_SPARE_HI,     32'h0000_0000, 8'd0,   1,  1'b1, ST_OK,    5'd6},
      '{ACT_REMOVE_FRONT, 32'h0000_0000, 8'd0,   1,  1'b1, ST_OK,    5'd5},
      '{ACT_REMOVE_END,   32'h0000_0000, 8'd0,   1,  1'b1, ST_OK,    5'd4},
      '{ACT_ADD_END,      32'h0001_0000, 8'd0,   12, 1'b0, ST_OK,    5'd0},
      '{ACT_ADD_FRONT,    32'h1234_5678, 8'd0,   1,  1'b1, ST_FULL,  5'd16},
      '{ACT_ADD_END,      32'h1234_5678, 8'd0,   1,  1'b1, ST_FULL,  5'd16},
      '{ACT_INSERT_AT,    32'h1234_5678, 8'd255, 1,  1'b1, ST_FULL,  5'd16},
      '{ACT_READOUT,      32'h0000_0000, 8'd0,   1,  1'b0, ST_OK,    5'd0},
      '{ACT_REMOVE_FRONT, 32'h0000_0000, 8'd0,   15, 1'b0, ST_OK,    5'd0},
      '{ACT_REMOVE_END,   32'h0000_0000, 8'd0,   1,  1'b1, ST_OK,    5'd0},
      '{ACT_REMOVE_FRONT, 32'h0000_0000, 8'd0,   1,  1'b1, ST_EMPTY, 5'd0},
      '{ACT_INSERT_AT,    32'h1234_5678, 8'd128, 1,  1'b1, ST_RANGE, 5'd0}
   };

   localparam mix_type PHASE_MIX [NUM_PHASES] = '{
      MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_FILL, MIX_EVEN, MIX_DRAIN, MIX_FILL, MIX_EVEN
   };

   logic clock = 1'b0;
   logic reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;  // value[31:0], position[39:32]
   logic [ACTION_W-1:0]   req_tuser;  // action[2:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;  // status[1:0], item_value[33:2], entry_count[38:34]
   logic                  rsp_tuser;  // item_valid[0]
   logic                  rsp_tlast;

   // Model of the list and the replies still owed by the block
   logic [DATA_W-1:0] list_entries [$];
   list_reply_type    pending_replies [$];

   // Typed expectation of the item currently offered
   bit                   row_typed;
   status_type           row_status;
   logic [OUT_CNT_W-1:0] row_count;

   // Handshake bookkeeping shared with the receiver
   bit rsp_taken;
   bit long_hold_req;

   // Idle stretches of the sender
   int  send_run_left;
   bit  send_quiet;

   int cycle_count;
   int mismatch_count;
   int items_taken, replies_checked, readouts, full_hits, empty_hits, range_hits;
   int deepest;

   bounded_ordered_list_top #(.CAPACITY(LIST_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout: %0d replies still owed", pending_replies.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // Applies one accepted item to the model list and queues its replies
   function automatic void apply_list_action(logic [ACTION_W-1:0] act,
                                             logic [DATA_W-1:0] val,
                                             logic [POS_W-1:0] pos);
      status_type st;
      int         n;
      st = ST_OK;
      case (act)
         ACT_ADD_FRONT, ACT_ADD_END, ACT_INSERT_AT: begin
            if (list_entries.size() >= LIST_DEPTH) begin
               st = ST_FULL;
            end else if (act == ACT_ADD_FRONT || (act == ACT_INSERT_AT && pos <= 1)) begin
               list_entries.push_front(val);
            end else if (act == ACT_ADD_END) begin
               list_entries.push_back(val);
            end else if (int'(pos) > list_entries.size() + 1) begin
               st = ST_RANGE;
            end else begin
               list_entries.insert(int'(pos) - 1, val);
            end
         end
         ACT_REMOVE_FRONT: begin
            if (list_entries.size() == 0) st = ST_EMPTY;
            else void'(list_entries.pop_front());
         end
         ACT_REMOVE_END: begin
            if (list_entries.size() == 0) st = ST_EMPTY;
            else void'(list_entries.pop_back());
         end
         ACT_READOUT: begin
            readouts++;
            n = list_entries.size();
            if (n == 0) begin
               pending_replies.push_back('{ST_OK, '0, 1'b0, 1'b1, '0});
            end else begin
               for (int i = 0; i < n; i++)
                  pending_replies.push_back('{ST_OK, list_entries[i], 1'b1, (i == n - 1),
                                              OUT_CNT_W'(n)});
            end
            return;
         end
         default: ;  // unused codes change nothing
      endcase
      if (st == ST_FULL)  full_hits++;
      if (st == ST_EMPTY) empty_hits++;
      if (st == ST_RANGE) range_hits++;
      if (list_entries.size() > deepest) deepest = list_entries.size();
      pending_replies.push_back('{st, '0, 1'b0, 1'b1, OUT_CNT_W'(list_entries.size())});
   endfunction

   // Compares one reply with the oldest one owed
   function automatic void check_reply(list_reply_type got);
      list_reply_type want;
      replies_checked++;
      if (pending_replies.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("%0t: unexpected reply st=%0d val=%h valid=%b last=%b cnt=%0d",
                     $realtime, got.st, got.val, got.valid, got.last, got.cnt);
         return;
      end
      want = pending_replies.pop_front();
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("%0t: mismatch exp %0d %h %b %b %0d, got %0d %h %b %b %0d",
                     $realtime, want.st, want.val, want.valid, want.last, want.cnt,
                     got.st, got.val, got.valid, got.last, got.cnt);
      end
   endfunction

   // Both channels sampled at the rising edge
   always @(posedge clock) begin
      rsp_taken = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            items_taken++;
            apply_list_action(req_tuser, req_tdata[DATA_W-1:0], req_tdata[DATA_W +: POS_W]);
            // typed rows replace the model's single status reply
            if (row_typed) begin
               void'(pending_replies.pop_back());
               pending_replies.push_back('{row_status, '0, 1'b0, 1'b1, row_count});
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_taken = 1'b1;
            check_reply('{status_type'(rsp_tdata[STATUS_W-1:0]),
                          rsp_tdata[STATUS_W +: DATA_W], rsp_tuser, rsp_tlast,
                          rsp_tdata[STATUS_W + DATA_W +: OUT_CNT_W]});
         end
      end
   end

   // Receiver: random stall per reply, quiet stretches, one long hold-off
   initial begin
      int  stall_left;
      int  run_left;
      bit  quiet;
      stall_left = 0;
      run_left   = 0;
      quiet      = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left    = LONG_HOLD;
         end else if (rsp_taken) begin
            if (run_left == 0) begin
               quiet    = ($urandom_range(0, 2) == 0);
               run_left = $urandom_range(8, 30);
            end
            run_left--;
            stall_left = quiet ? 0 : $urandom_range(0, 16);
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Offers one item after a random gap and returns at the falling edge after it is taken
   task automatic send_item(logic [ACTION_W-1:0] act, logic [DATA_W-1:0] val,
                            logic [POS_W-1:0] pos, bit no_gap, bit typed,
                            status_type st, logic [OUT_CNT_W-1:0] cnt);
      int gap;
      if (send_run_left == 0) begin
         send_quiet    = ($urandom_range(0, 2) == 0);
         send_run_left = $urandom_range(8, 30);
      end
      send_run_left--;
      gap = (send_quiet || no_gap) ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      row_typed  = typed;
      row_status = st;
      row_count  = cnt;
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {pos, val};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Stops offering and waits until every owed reply has arrived
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Random item shaped by the phase: fill, drain or even mix
   function automatic void draw_random_item(mix_type mix, output logic [ACTION_W-1:0] act,
                                            output logic [DATA_W-1:0] val,
                                            output logic [POS_W-1:0] pos);
      int r;
      r = $urandom_range(0, 99);
      case (mix)
         MIX_FILL:
            act = (r < 30) ? ACT_ADD_FRONT : (r < 60) ? ACT_ADD_END :
                  (r < 85) ? ACT_INSERT_AT : (r < 93) ? ACT_READOUT :
                  (r < 96) ? ACT_REMOVE_FRONT : (r < 98) ? ACT_REMOVE_END : ACT_SPARE_LO;
         MIX_DRAIN:
            act = (r < 8) ? ACT_ADD_FRONT : (r < 16) ? ACT_ADD_END :
                  (r < 24) ? ACT_INSERT_AT : (r < 34) ? ACT_READOUT :
                  (r < 66) ? ACT_REMOVE_FRONT : (r < 98) ? ACT_REMOVE_END : ACT_SPARE_HI;
         default:
            act = (r < 15) ? ACT_ADD_FRONT : (r < 30) ? ACT_ADD_END :
                  (r < 50) ? ACT_INSERT_AT : (r < 65) ? ACT_READOUT :
                  (r < 80) ? ACT_REMOVE_FRONT : (r < 97) ? ACT_REMOVE_END :
                  (r < 98) ? ACT_SPARE_LO : ACT_SPARE_HI;
      endcase
      // mostly reachable positions, sometimes anything
      if ($urandom_range(0, 9) == 0) pos = POS_W'($urandom_range(0, 255));
      else pos = POS_W'($urandom_range(0, list_entries.size() + 2));
      if ($urandom_range(0, 9) == 0) begin
         case ($urandom_range(0, 3))
            0:       val = 32'h8000_0000;
            1:       val = 32'h7FFF_FFFF;
            2:       val = 32'hFFFF_FFFF;
            default: val = 32'h0000_0000;
         endcase
      end else begin
         val = $urandom;
      end
   endfunction

   // Stimulus
   initial begin
      logic [ACTION_W-1:0] act;
      logic [DATA_W-1:0]   val;
      logic [POS_W-1:0]    pos;
      stim_row_type        row;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = '0;
      row_typed     = 1'b0;
      row_status    = ST_OK;
      row_count     = '0;
      long_hold_req = 1'b0;
      send_run_left = 0;
      send_quiet    = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         row = DIRECTED_ROWS[i];
         for (int k = 0; k < row.reps; k++)
            send_item(row.act, row.val + k, row.pos, 1'b0, row.typed, row.st, row.cnt);
      end
      wait_for_drain();

      // Random phases; the pressure phase floods the block during a long hold-off
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase == PRESSURE_PHASE) long_hold_req = 1'b1;
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            draw_random_item(PHASE_MIX[phase], act, val, pos);
            send_item(act, val, pos, (phase == PRESSURE_PHASE && k < PRESSURE_ITEMS),
                      1'b0, ST_OK, '0);
         end
         wait_for_drain();
      end

      // Catch any stray reply
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d items, checked %0d replies, %0d readouts, deepest list %0d.",
               items_taken, replies_checked, readouts, deepest);
      $display("Status cases seen: full %0d, empty %0d, out of range %0d; mismatches %0d.",
               full_hits, empty_hits, range_hits, mismatch_count);
      if (mismatch_count == 0 && pending_replies.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### bounded_ordered_list_top.f
+incdir+design
design/bol_pkg.sv
design/bol_cell.sv
design/bounded_ordered_list_top.sv
test/testbench.sv
